@@ rtl/core/sorted_set_engine_assert.svh @@
// Assertion macros used by the checker file.
`ifndef SORTED_SET_ENGINE_ASSERT_SVH
`define SORTED_SET_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted set check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define SSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted set check failed");

`endif

@@ rtl/core/sse_pkg.sv @@
package sse_pkg;

  // Default sizes
  localparam int CAPACITY_DEF    = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  // Cells per registered OR group
  localparam int GROUP_SIZE = 16;

  // Fixed port field widths
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 8;
  localparam int RDV_W   = 32;
  localparam int ICNT_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_ERASE    = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_GET      = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key_value;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [RDV_W-1:0]  read_value;
    logic [ICNT_W-1:0] item_count;
  } out_item_t;

  // Strobes from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctl_t;

endpackage

@@ rtl/core/sse_cell.sv @@
module sse_cell #(
  parameter int VALUE_WIDTH = sse_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = 9,
  parameter int IDX         = 0
) (
  input  logic                      clk,
  input  sse_pkg::cell_ctl_t        ctl,
  input  logic [VALUE_WIDTH-1:0]    key,
  input  logic [CNT_W-1:0]          count,
  input  logic [sse_pkg::POS_W-1:0] pos,
  input  logic [VALUE_WIDTH-1:0]    prev_entry,
  input  logic                      prev_lt,
  input  logic [VALUE_WIDTH-1:0]    next_entry,
  output logic [VALUE_WIDTH-1:0]    entry,
  output logic                      lt,
  output logic                      eq,
  output logic [VALUE_WIDTH-1:0]    sel_data
);

  localparam bit REACH = (IDX < (1 << sse_pkg::POS_W));

  logic [VALUE_WIDTH-1:0] entry_r, entry_nxt;
  logic                   lt_r, eq_r, sel_r;
  logic                   valid;
  logic                   pos_hit;

  assign valid   = (count > CNT_W'(IDX));
  assign pos_hit = REACH && (pos == sse_pkg::POS_W'(IDX));

  // Compare flags, held until the next command
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_r  <= valid && (entry_r < key);
      eq_r  <= valid && (entry_r == key);
      sel_r <= valid && pos_hit;
    end
  end

  // Shift up on insert, down on erase, from the first cell not below the key upward
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && !lt_r) begin
      entry_nxt = prev_lt ? key : prev_entry;
    end else if (ctl.del_en && !lt_r) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry    = entry_r;
  assign lt       = lt_r;
  assign eq       = eq_r;
  assign sel_data = sel_r ? entry_r : '0;

endmodule

@@ rtl/core/sse_group.sv @@
module sse_group #(
  parameter int VALUE_WIDTH = sse_pkg::VALUE_WIDTH_DEF,
  parameter int N           = sse_pkg::GROUP_SIZE
) (
  input  logic                            clk,
  input  logic [N-1:0]                    eq,
  input  logic [N-1:0][VALUE_WIDTH-1:0]   data,
  output logic                            any_hit,
  output logic [VALUE_WIDTH-1:0]          any_data
);

  logic                   any_r, any_nxt;
  logic [VALUE_WIDTH-1:0] data_r, data_nxt;

  // Fold the group's match bits and selected words
  always_comb begin
    any_nxt  = 1'b0;
    data_nxt = '0;
    for (int k = 0; k < N; k++) begin
      any_nxt  = any_nxt | eq[k];
      data_nxt = data_nxt | data[k];
    end
  end

  always_ff @(posedge clk) begin
    any_r  <= any_nxt;
    data_r <= data_nxt;
  end

  assign any_hit  = any_r;
  assign any_data = data_r;

endmodule

@@ rtl/core/sorted_set_engine.sv @@
// Channel | Direction | Payload               | Handshake
// in      | input     | sse_pkg::in_item_t    | in_valid / in_stall
// out     | output    | sse_pkg::out_item_t   | out_valid / out_stall
//
// out_valid rises once a transferred command has passed through compare in all cells,
// fold of the match flags through a registered group stage, then the
// shift/update and result load. No new command is taken until the current
// one has finished its last step. One command is in the cell row at a time.
// Reset clears the entry count and control; cell contents need no reset.
// A result held by out_stall lets one more command in; that command then waits
// in its last step, with in_stall high, until the held result is taken.
module sorted_set_engine #(
  parameter int CAPACITY    = sse_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = sse_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sse_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sse_pkg::out_item_t  out_data
);

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int GS      = sse_pkg::GROUP_SIZE;
  localparam int NGROUPS = (CAPACITY + GS - 1) / GS;
  localparam int PCNT_W  = (CNT_W > sse_pkg::POS_W) ? CNT_W : sse_pkg::POS_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_RED  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  sse_pkg::cmd_t               cmd_r;
  logic [VALUE_WIDTH-1:0]      key_r;
  logic [sse_pkg::POS_W-1:0]   pos_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  sse_pkg::out_item_t          out_r;

  sse_pkg::cell_ctl_t          ctl;
  logic                        in_xfer, fire;
  logic                        found, ok;
  logic [VALUE_WIDTH-1:0]      get_data;
  logic                        pos_ok;

  logic [VALUE_WIDTH-1:0]      entry_w [CAPACITY];
  logic                        lt_w    [CAPACITY];
  logic [NGROUPS*GS-1:0]                  eq_pad;
  logic [NGROUPS*GS-1:0][VALUE_WIDTH-1:0] data_pad;
  logic [NGROUPS-1:0]                     grp_hit;
  logic [VALUE_WIDTH-1:0]                 grp_data [NGROUPS];

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign fire     = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_e, next_e, sel_d;
    logic                   prev_l, eq_l;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_l = 1'b1;
    end else begin : g_mid
      assign prev_e = entry_w[i-1];
      assign prev_l = lt_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entry_w[i+1];
    end
    sse_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .IDX         (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (key_r),
      .count      (count_r),
      .pos        (pos_r),
      .prev_entry (prev_e),
      .prev_lt    (prev_l),
      .next_entry (next_e),
      .entry      (entry_w[i]),
      .lt         (lt_w[i]),
      .eq         (eq_l),
      .sel_data   (sel_d)
    );
    assign eq_pad[i]   = eq_l;
    assign data_pad[i] = sel_d;
  end

  // Pad the last group
  for (genvar k = CAPACITY; k < NGROUPS * GS; k++) begin : g_pad
    assign eq_pad[k]   = 1'b0;
    assign data_pad[k] = '0;
  end

  // Registered group fold
  for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
    sse_group #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .N           (GS)
    ) u_group (
      .clk      (clk),
      .eq       (eq_pad[g*GS +: GS]),
      .data     (data_pad[g*GS +: GS]),
      .any_hit  (grp_hit[g]),
      .any_data (grp_data[g])
    );
  end

  // Final fold over the groups
  always_comb begin
    found    = 1'b0;
    get_data = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      found    = found | grp_hit[g];
      get_data = get_data | grp_data[g];
    end
  end

  assign pos_ok = (PCNT_W'(pos_r) < PCNT_W'(count_r));

  // Command outcome
  always_comb begin
    ok = 1'b0;
    unique case (cmd_r)
      sse_pkg::CMD_INSERT:   ok = (count_r < CNT_W'(CAPACITY)) && !found;
      sse_pkg::CMD_ERASE:    ok = found;
      sse_pkg::CMD_CONTAINS: ok = found;
      sse_pkg::CMD_GET:      ok = pos_ok;
      default:               ok = 1'b0;
    endcase
  end

  always_comb begin
    ctl.cmp_en = (state_r == ST_CMP);
    ctl.ins_en = fire && ok && (cmd_r == sse_pkg::CMD_INSERT);
    ctl.del_en = fire && ok && (cmd_r == sse_pkg::CMD_ERASE);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_FIN;
      ST_FIN:  if (fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Count update
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Hold result until transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Latch the accepted command
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= sse_pkg::cmd_t'(in_data.cmd);
      key_r <= VALUE_WIDTH'(in_data.key_value);
      pos_r <= in_data.position;
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.ok         <= ok;
      out_r.read_value <= ((cmd_r == sse_pkg::CMD_GET) && ok) ?
                          sse_pkg::RDV_W'(get_data) : '0;
      out_r.item_count <= sse_pkg::ICNT_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/sse_checker.sv @@
`include "sorted_set_engine_assert.svh"

module sse_checker #(
  parameter int CAPACITY = sse_pkg::CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input sse_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input sse_pkg::out_item_t out_data
);

  localparam int LIM = (CAPACITY < 511) ? CAPACITY : 511;

  logic [sse_pkg::CMD_W-1:0]  cmd_q0_r, cmd_q0_nxt;
  logic [sse_pkg::CMD_W-1:0]  cmd_q1_r, cmd_q1_nxt;
  logic [1:0]                 fill_r, fill_nxt;
  logic [sse_pkg::ICNT_W-1:0] last_cnt_r;
  logic [sse_pkg::ICNT_W-1:0] grow_cnt;
  logic                       in_xfer, out_xfer;
  logic                       is_get, is_ins;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign is_get   = (cmd_q0_r == sse_pkg::CMD_GET);
  assign is_ins   = (cmd_q0_r == sse_pkg::CMD_INSERT);
  assign grow_cnt = last_cnt_r + sse_pkg::ICNT_W'(1);

  // Queue the commands in flight; the head belongs to the result on out_data
  always_comb begin
    cmd_q0_nxt = cmd_q0_r;
    cmd_q1_nxt = cmd_q1_r;
    fill_nxt   = fill_r;
    if (out_xfer) begin
      cmd_q0_nxt = cmd_q1_r;
      fill_nxt   = fill_nxt - 2'd1;
    end
    if (in_xfer) begin
      if (fill_nxt == 2'd0) begin
        cmd_q0_nxt = in_data.cmd;
      end else begin
        cmd_q1_nxt = in_data.cmd;
      end
      fill_nxt = fill_nxt + 2'd1;
    end
  end

  // Track the queued commands and the count from the last result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_q0_r   <= sse_pkg::CMD_INSERT;
      cmd_q1_r   <= sse_pkg::CMD_INSERT;
      fill_r     <= 2'd0;
      last_cnt_r <= '0;
    end else begin
      cmd_q0_r <= cmd_q0_nxt;
      cmd_q1_r <= cmd_q1_nxt;
      fill_r   <= fill_nxt;
      if (out_xfer) begin
        last_cnt_r <= out_data.item_count;
      end
    end
  end

  `SSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SSE_ASSERT_NOW(a_cnt_cap, out_valid, out_data.item_count <= sse_pkg::ICNT_W'(LIM))
  `SSE_ASSERT_NOW(a_rd_zero, out_valid && (!is_get || !out_data.ok), out_data.read_value == '0)
  `SSE_ASSERT_NOW(a_ins_grow, out_valid && is_ins && out_data.ok, out_data.item_count == grow_cnt)

endmodule

bind sorted_set_engine sse_checker #(
  .CAPACITY (CAPACITY)
) u_sse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
